// ===== rtl/sha1_message_digest_assert.svh =====
// Assertion macros for the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SHA1MD_CHECK(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define SHA1MD_CHECK_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sha1md_pkg.sv =====
`default_nettype none

package sha1md_pkg;

  localparam int WORDS = 5;

  localparam logic [31:0] IV [WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] PAD_ZERO = 8'h00;

  localparam logic [5:0] FILL_LEN  = 6'd56;
  localparam logic [5:0] FILL_FULL = 6'd63;

  localparam logic [6:0] ROUND_P1   = 7'd20;
  localparam logic [6:0] ROUND_P2   = 7'd40;
  localparam logic [6:0] ROUND_P3   = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam logic [2:0] LAST_IDX = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic fold;
    logic init;
  } core_ctl_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       shift_word;
  } sched_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sha1md_sched.sv =====
`default_nettype none

module sha1md_sched (
  input  wire logic                  clk,
  input  wire sha1md_pkg::sched_ctl_t ctl,
  output logic [31:0]                w_cur
);

  logic [511:0] win;
  logic [31:0]  mix;
  logic [31:0]  w_new;

  assign w_cur = win[511:480];
  assign mix   = win[511:480] ^ win[447:416] ^ win[255:224] ^ win[95:64];
  assign w_new = {mix[30:0], mix[31]};

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      win <= {win[503:0], ctl.byte_val};
    end else if (ctl.shift_word) begin
      win <= {win[479:0], w_new};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha1md_core.sv =====
`default_nettype none

module sha1md_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sha1md_pkg::core_ctl_t ctl,
  input  wire logic [31:0]          w_cur,
  output logic                      round_last,
  output logic [31:0]               chain [sha1md_pkg::WORDS]
);

  logic [31:0] a, b, c, d, e;
  logic [6:0]  cnt;
  logic [31:0] f, k, t;

  assign round_last = (cnt == sha1md_pkg::ROUND_LAST);

  always_comb begin
    if (cnt < sha1md_pkg::ROUND_P1) begin
      f = d ^ (b & (c ^ d));
      k = sha1md_pkg::K0;
    end else if (cnt < sha1md_pkg::ROUND_P2) begin
      f = b ^ c ^ d;
      k = sha1md_pkg::K1;
    end else if (cnt < sha1md_pkg::ROUND_P3) begin
      f = (b & c) | (d & (b | c));
      k = sha1md_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1md_pkg::K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= sha1md_pkg::IV;
      cnt   <= '0;
    end else begin
      if (ctl.init) begin
        chain <= sha1md_pkg::IV;
      end else if (ctl.fold) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (ctl.start) begin
        cnt <= '0;
      end else if (ctl.step) begin
        cnt <= cnt + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctl.step) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha1md_ctrl.sv =====
`default_nettype none

module sha1md_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   has_byte,
  input  wire logic                   is_last,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  out_idx,
  input  wire logic                   round_last,
  output sha1md_pkg::core_ctl_t       core_ctl,
  output sha1md_pkg::sched_ctl_t      sched_ctl
);

  sha1md_pkg::state_t state, state_next;
  sha1md_pkg::state_t ret, ret_next;
  logic [5:0]  fill;
  logic [60:0] byte_count;
  logic [63:0] bit_len;
  logic        shift;
  logic        full;
  logic        msg_byte;
  logic        out_done;

  assign bit_len  = {byte_count, 3'b000};
  assign msg_byte = (state == sha1md_pkg::ST_IDLE) && in_valid && has_byte;
  assign out_done = (state == sha1md_pkg::ST_OUT) && out_ready &&
                    (out_idx == sha1md_pkg::LAST_IDX);

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      sha1md_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (full) begin
            state_next = sha1md_pkg::ST_ROUND;
            ret_next   = is_last ? sha1md_pkg::ST_MARK : sha1md_pkg::ST_IDLE;
          end else if (is_last) begin
            state_next = sha1md_pkg::ST_MARK;
          end
        end
      end
      sha1md_pkg::ST_MARK: begin
        if (full) begin
          state_next = sha1md_pkg::ST_ROUND;
          ret_next   = sha1md_pkg::ST_ZERO;
        end else begin
          state_next = sha1md_pkg::ST_ZERO;
        end
      end
      sha1md_pkg::ST_ZERO: begin
        if (fill == sha1md_pkg::FILL_LEN) begin
          state_next = sha1md_pkg::ST_LEN;
        end else if (full) begin
          state_next = sha1md_pkg::ST_ROUND;
          ret_next   = sha1md_pkg::ST_ZERO;
        end
      end
      sha1md_pkg::ST_LEN: begin
        if (full) begin
          state_next = sha1md_pkg::ST_ROUND;
          ret_next   = sha1md_pkg::ST_OUT;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        if (round_last) begin
          state_next = sha1md_pkg::ST_FOLD;
        end
      end
      sha1md_pkg::ST_FOLD: begin
        state_next = ret;
      end
      sha1md_pkg::ST_OUT: begin
        if (out_done) begin
          state_next = sha1md_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sha1md_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == sha1md_pkg::ST_IDLE);
    out_valid = (state == sha1md_pkg::ST_OUT);
    shift     = 1'b0;
    sched_ctl = '0;
    unique case (state)
      sha1md_pkg::ST_IDLE: begin
        shift              = msg_byte;
        sched_ctl.byte_val = data_byte;
      end
      sha1md_pkg::ST_MARK: begin
        shift              = 1'b1;
        sched_ctl.byte_val = sha1md_pkg::PAD_MARK;
      end
      sha1md_pkg::ST_ZERO: begin
        shift              = (fill != sha1md_pkg::FILL_LEN);
        sched_ctl.byte_val = sha1md_pkg::PAD_ZERO;
      end
      sha1md_pkg::ST_LEN: begin
        shift              = 1'b1;
        sched_ctl.byte_val = bit_len[{~fill[2:0], 3'b000} +: 8];
      end
      sha1md_pkg::ST_ROUND: begin
        sched_ctl.shift_word = 1'b1;
      end
      default: begin
        shift = 1'b0;
      end
    endcase
    sched_ctl.shift_byte = shift;
    full          = shift && (fill == sha1md_pkg::FILL_FULL);
    core_ctl.start = full;
    core_ctl.step  = (state == sha1md_pkg::ST_ROUND);
    core_ctl.fold  = (state == sha1md_pkg::ST_FOLD);
    core_ctl.init  = out_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha1md_pkg::ST_IDLE;
      ret        <= sha1md_pkg::ST_IDLE;
      fill       <= '0;
      byte_count <= '0;
      out_idx    <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (out_done) begin
        fill       <= '0;
        byte_count <= '0;
        out_idx    <= '0;
      end else begin
        if (shift) begin
          fill <= fill + 6'd1;
        end
        if (msg_byte) begin
          byte_count <= byte_count + 61'd1;
        end
        if (out_valid && out_ready) begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha1_message_digest.sv =====
// Channel   Group    tdata              tuser           tlast
// input     s_axis   [7:0] data_byte    has_byte        is_last
// output    m_axis   [31:0] digest_word [2:0] word_index last_word
//
// A byte that does not complete a 64-byte block is only shifted in; one that
// completes it runs load, 80 rounds of the shared round unit and fold, with
// no input taken meanwhile. A last item adds the padding bytes, an empty
// step before the length bytes, rounds and fold of each padded block (one or
// two), then holds for five output transfers; no input is taken until then.
// Reset loads the initial vector and clears the counts; no clearing pass.
`default_nettype none

`include "sha1_message_digest_assert.svh"

module sha1_message_digest (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast
);

  sha1md_pkg::core_ctl_t  core_ctl;
  sha1md_pkg::sched_ctl_t sched_ctl;
  logic [31:0] w_cur;
  logic        round_last;
  logic [31:0] chain [sha1md_pkg::WORDS];
  logic [2:0]  out_idx;

  sha1md_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .data_byte  (s_axis_tdata),
    .has_byte   (s_axis_tuser),
    .is_last    (s_axis_tlast),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_idx    (out_idx),
    .round_last (round_last),
    .core_ctl   (core_ctl),
    .sched_ctl  (sched_ctl)
  );

  sha1md_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  sha1md_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctl        (core_ctl),
    .w_cur      (w_cur),
    .round_last (round_last),
    .chain      (chain)
  );

  always_comb begin
    case (out_idx)
      3'd0:    m_axis_tdata = chain[0];
      3'd1:    m_axis_tdata = chain[1];
      3'd2:    m_axis_tdata = chain[2];
      3'd3:    m_axis_tdata = chain[3];
      default: m_axis_tdata = chain[4];
    endcase
  end

  assign m_axis_tuser = out_idx;
  assign m_axis_tlast = (out_idx == sha1md_pkg::LAST_IDX);

  `SHA1MD_CHECK(a_side_excl, !(s_axis_tready && m_axis_tvalid), "input and output both open")
  `SHA1MD_CHECK(a_ctl_onehot, $onehot0(core_ctl), "core controls overlap")
  `SHA1MD_CHECK(a_idx_range, !m_axis_tvalid || (out_idx <= sha1md_pkg::LAST_IDX), "word index out of range")
  `SHA1MD_CHECK_NEXT(a_done_ready, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && !m_axis_tvalid, "no return to idle after digest")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 235;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic [31:0]  chain_word [sha1md_pkg::WORDS];
  logic [7:0]   msg_block [64];
  logic [60:0]  msg_len;
  digest_beat_t digest_fifo [$];

  int error_count = 0;
  int stall_cycles = 0;
  int items_sent = 0;
  bit src_lazy = 1'b1;
  bit sink_lazy = 1'b1;

  sha1_message_digest i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void clear_digest_state();
    for (int i = 0; i < sha1md_pkg::WORDS; i++) chain_word[i] = sha1md_pkg::IV[i];
    for (int i = 0; i < 64; i++) msg_block[i] = sha1md_pkg::PAD_ZERO;
    msg_len = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = chain_word[0];
    b = chain_word[1];
    c = chain_word[2];
    d = chain_word[3];
    e = chain_word[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = d ^ (b & (c ^ d));
        k = sha1md_pkg::K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K1;
      end else if (i < 60) begin
        f = (b & c) | (d & (b | c));
        k = sha1md_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K3;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_word[0] += a;
    chain_word[1] += b;
    chain_word[2] += c;
    chain_word[3] += d;
    chain_word[4] += e;
  endfunction

  function automatic void absorb_item(logic [7:0] data, logic has_byte, logic is_last);
    logic [63:0] bit_len;
    int pos;
    digest_beat_t beat;
    if (has_byte) begin
      pos = int'(msg_len[5:0]);
      msg_block[pos] = data;
      msg_len = msg_len + 61'd1;
      if (pos == 63) fold_block();
    end
    if (!is_last) return;
    bit_len = {msg_len, 3'b000};
    pos = int'(msg_len[5:0]);
    msg_block[pos] = sha1md_pkg::PAD_MARK;
    pos = pos + 1;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = sha1md_pkg::PAD_ZERO;
        pos = pos + 1;
      end
      fold_block();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = sha1md_pkg::PAD_ZERO;
      pos = pos + 1;
    end
    for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
    fold_block();
    for (int i = 0; i < sha1md_pkg::WORDS; i++) begin
      beat.word = chain_word[i];
      beat.index = 3'(i);
      beat.last = (3'(i) == sha1md_pkg::LAST_IDX);
      digest_fifo.push_back(beat);
    end
    clear_digest_state();
  endfunction

  initial clear_digest_state();

  always @(posedge clk) begin
    digest_beat_t beat;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_fifo.size() == 0) begin
          $display("%0t: unexpected transfer: word %h index %0d last %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          error_count++;
        end else begin
          beat = digest_fifo.pop_front();
          if (m_axis_tdata !== beat.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, beat.word, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tuser !== beat.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, beat.index, m_axis_tuser);
            error_count++;
          end
          if (m_axis_tlast !== beat.last) begin
            $display("%0t: last_word expected %b actual %b", $time, beat.last, m_axis_tlast);
            error_count++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_lazy = ~sink_lazy;
      gap = sink_lazy ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
    end
  end

  task automatic send_item(logic [7:0] data, logic has_byte, logic is_last);
    int gap;
    if ($urandom_range(0, 15) == 0) src_lazy = ~src_lazy;
    gap = src_lazy ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= data;
    s_axis_tuser <= has_byte;
    s_axis_tlast <= is_last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(int len, bit split_last, bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !split_last);
    end
    if (len == 0 || split_last) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_noop_items();
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h3C, 1'b1, 1'b1);
  endtask

  task automatic test_short_messages();
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_messages();
    int start;
    int len;
    int room;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: len = 0;
        1, 2: begin
          case ($urandom_range(0, 7))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            default: len = 120;
          endcase
        end
        default: len = $urandom_range(1, 24);
      endcase
      room = RANDOM_ITEMS - (items_sent - start);
      if (len >= room) len = room - 1;
      send_message(len, 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_noop_items();
    test_short_messages();
    test_random_messages();
    s_axis_tvalid <= 1'b0;
    while (digest_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
